// ===== rtl/cscan_pkg.sv =====
// Shared types and constants for the C-SCAN disk schedule order block.
// No dependencies; imported by every module under rtl/.
package cscan_pkg;

  localparam int MAX_REQUESTS_DEF = 16;

  localparam int CYL_W  = 8;
  localparam int MOVE_W = 10;

  localparam logic [CYL_W-1:0]  CYL_LOW  = 8'd0;
  localparam logic [CYL_W-1:0]  CYL_HIGH = 8'd199;
  localparam logic [MOVE_W-1:0] MOVE_MAX = 10'd1023;

  // configuration register indexes
  localparam logic [7:0] CFG_HEAD_POSITION = 8'd0;
  localparam logic [7:0] CFG_SWEEP_UP      = 8'd1;

  // one request on its way from the front end to the sorter
  typedef struct packed {
    logic [CYL_W-1:0] cyl;   // already saturated
    logic             last;  // closes the batch
    logic             keep;  // fits in the store
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0] head;  // saturated head cylinder
    logic             sweep_up;
  } cfg_t;

  function automatic logic [CYL_W-1:0] sat_cyl(input logic [CYL_W-1:0] v);
    sat_cyl = (v > CYL_HIGH) ? CYL_HIGH : v;
  endfunction

endpackage

// ===== rtl/cscan_disk_schedule_order.sv =====
// C-SCAN disk schedule order generator, top level with configuration registers.
// Depends on cscan_pkg, cscan_front, cscan_queue and cscan_back.
//
// Usage:
//   Requests arrive on the s_* stream, one cylinder per transaction; s_tlast
//   closes the batch. Up to MAX_REQUESTS requests are kept per batch, later
//   ones are dropped (their tlast still closes the batch). Values above 199
//   are clamped to 199. After the closing transaction the block sorts in the
//   end cylinders and the head, then emits the circular-scan order on m_*,
//   stored + 3 transactions, m_tlast on the final one, which also carries the
//   total head movement (clamped to 1023; zero on the others).
//   Throughput: one request per cycle through a two-entry queue while the queue
//   is not full; the sorter inserts one value per cycle. The closing request is
//   followed by the insertions of the low end, the high end and the head, then
//   one result per cycle while m_tready stays high.
//   Requests of the next batch are taken into the queue while results drain.
//   A stalled receiver holds the output register; the emitter waits.
//   Configuration: cfg_index 0 is head_position, 1 is sweep_up; always ready.
//   The user must write it only while the block is idle; the block does not enforce it.
//   Reset clears the queue and counts and sets head 0, sweep upward.
module cscan_disk_schedule_order #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] request_cylinder
  input  logic        s_tlast,    // batch_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] service_cylinder, [17:8] total_movement
  output logic        m_tlast,    // order_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cscan_pkg::*;

  logic [CYL_W-1:0] head_position;
  logic             sweep_up;
  cfg_t             cfg;
  req_t             push_data;
  req_t             pop_data;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  assign cfg_ready    = 1'b1;
  assign cfg.head     = sat_cyl(head_position);
  assign cfg.sweep_up = sweep_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= '0;
      sweep_up      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAD_POSITION: head_position <= cfg_data;
        CFG_SWEEP_UP:      sweep_up      <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  cscan_front #(.MAX_REQUESTS(MAX_REQUESTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  cscan_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  cscan_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/cscan_front.sv =====
// Front end: takes request transactions, saturates them and decides whether
// each one still fits in the batch. Depends on cscan_pkg.
module cscan_front #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] request_cylinder
  input  logic                          s_tlast,   // batch_last
  input  logic                          q_full,
  output logic                          push,
  output cscan_pkg::req_t               push_data
);
  import cscan_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CNT_W-1:0] count;
  logic             keep;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;
  assign keep     = count < CNT_W'(MAX_REQUESTS);

  assign push_data.cyl  = sat_cyl(s_tdata);
  assign push_data.last = s_tlast;
  assign push_data.keep = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (s_tlast) begin
        count <= '0;
      end else if (keep) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cscan_queue.sv =====
// Two-entry queue between the front end and the sorter.
// Depends on cscan_pkg for the entry type.
module cscan_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cscan_pkg::req_t push_data,
  output logic            full,
  input  logic            pop,
  output cscan_pkg::req_t pop_data,
  output logic            empty
);
  import cscan_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/cscan_back.sv =====
// Back end: insertion-sorted cell row, end/head insertion and the circular
// emitter with movement sum and output register. Depends on cscan_pkg.
module cscan_back #(
  parameter int MAX_REQUESTS = cscan_pkg::MAX_REQUESTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cscan_pkg::cfg_t  cfg,
  input  logic             q_empty,
  input  cscan_pkg::req_t  q_data,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [7:0] service_cylinder, [17:8] total_movement
  output logic             m_tlast    // order_last
);
  import cscan_pkg::*;

  localparam int CAP   = MAX_REQUESTS + 3;
  localparam int IDX_W = $clog2(CAP);
  localparam int LEN_W = $clog2(CAP + 1);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_INS_LOW  = 3'd1;
  localparam logic [2:0] ST_INS_HIGH = 3'd2;
  localparam logic [2:0] ST_INS_HEAD = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  logic [2:0]        state;
  logic [CYL_W-1:0]  cells [CAP];
  logic [LEN_W-1:0]  len;
  logic [IDX_W-1:0]  ptr;
  logic [LEN_W-1:0]  remaining;
  logic [CYL_W-1:0]  prev;
  logic [MOVE_W-1:0] sum;

  logic [CYL_W-1:0]  ins_val;
  logic              ins_strict;
  logic              do_ins;
  logic [CAP-1:0]    moves;
  logic [CAP-1:0]    slot_hot;
  logic [IDX_W-1:0]  ins_pos;
  logic              out_free;
  logic              emit;
  logic [CYL_W-1:0]  cur;
  logic [CYL_W-1:0]  step;
  logic [MOVE_W:0]   sum_wide;
  logic [MOVE_W-1:0] sum_next;
  logic              is_last;
  logic [IDX_W-1:0]  ptr_next;

  assign pop      = (state == ST_LOAD) && !q_empty;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_EMIT) && out_free;

  always_comb begin
    ins_val    = q_data.cyl;
    ins_strict = 1'b0;
    do_ins     = 1'b0;
    case (state)
      ST_LOAD:     do_ins = pop && q_data.keep;
      ST_INS_LOW:  begin ins_val = CYL_LOW;  do_ins = 1'b1; end
      ST_INS_HIGH: begin ins_val = CYL_HIGH; do_ins = 1'b1; end
      ST_INS_HEAD: begin
        // head goes ahead of equal entries on an upward sweep, after them downward
        ins_val    = cfg.head;
        ins_strict = cfg.sweep_up;
        do_ins     = 1'b1;
      end
      default:     do_ins = 1'b0;
    endcase
  end

  // thermometer of cells that move one place right; empty cells count as larger
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      moves[i] = (LEN_W'(i) >= len) ||
                 (ins_strict ? (cells[i] >= ins_val) : (cells[i] > ins_val));
    end
    for (int i = 0; i < CAP; i++) begin
      slot_hot[i] = moves[i] && ((i == 0) || !moves[(i == 0) ? 0 : i - 1]);
    end
    ins_pos = '0;
    for (int i = 0; i < CAP; i++) begin
      ins_pos = ins_pos | (slot_hot[i] ? IDX_W'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < CAP; i++) begin
        if (moves[i]) begin
          cells[i] <= slot_hot[i] ? ins_val : cells[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // emitter datapath
  always_comb begin
    cur      = cells[ptr];
    step     = (cur > prev) ? cur - prev : prev - cur;
    sum_wide = {1'b0, sum} + {{(MOVE_W + 1 - CYL_W){1'b0}}, step};
    sum_next = sum_wide[MOVE_W] ? MOVE_MAX : sum_wide[MOVE_W-1:0];
    is_last  = remaining == LEN_W'(1);
    if (cfg.sweep_up) begin
      ptr_next = (LEN_W'(ptr) == len - 1'b1) ? '0 : ptr + 1'b1;
    end else begin
      ptr_next = (ptr == '0) ? IDX_W'(len - 1'b1) : ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      len       <= '0;
      ptr       <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_ins) len <= len + 1'b1;
      case (state)
        ST_LOAD: begin
          if (pop && q_data.last) state <= ST_INS_LOW;
        end
        ST_INS_LOW:  state <= ST_INS_HIGH;
        ST_INS_HIGH: state <= ST_INS_HEAD;
        ST_INS_HEAD: begin
          ptr       <= ins_pos;
          remaining <= len + 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            ptr       <= ptr_next;
            remaining <= remaining - 1'b1;
            if (is_last) begin
              len   <= '0;
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_INS_HEAD) begin
      prev <= cfg.head;
      sum  <= '0;
    end else if (emit) begin
      prev    <= cur;
      sum     <= sum_next;
      m_tdata <= {6'd0, (is_last ? sum_next : {MOVE_W{1'b0}}), cur};
      m_tlast <= is_last;
    end
  end

endmodule

// ===== tb/tb_cscan_disk_schedule_order.sv =====
// Self-checking testbench for the C-SCAN disk schedule order block.
// Needs cscan_pkg and cscan_disk_schedule_order; predicts each service order
// from the accepted requests and checks every output transaction against it.
`timescale 1ns / 1ps

module tb_cscan_disk_schedule_order;
  import cscan_pkg::*;

  localparam int MAX_REQ       = MAX_REQUESTS_DEF;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 46;
  localparam logic [7:0] CFG_SPARE_IDX = 8'd2;   // no register behind these
  localparam logic [7:0] CFG_TOP_IDX   = 8'hFF;

  typedef struct packed {
    logic [7:0] cyl;
    logic       closes;
  } disk_req_t;

  typedef struct packed {
    logic [7:0] cyl;
    logic       last;
    logic [9:0] moved;
  } visit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;      // [7:0] request_cylinder
  logic        s_tlast = 1'b0;      // batch_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;             // [7:0] service_cylinder, [17:8] total_movement
  logic        m_tlast;             // order_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;

  disk_req_t  pending_reqs[$];
  visit_t     expected_visits[$];
  logic [7:0] batch_cyls[$];

  // predictor copy of the registers
  logic [7:0] head_reg  = 8'd0;
  logic       sweep_reg = 1'b1;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int src_gap       = 0;
  int sink_gap      = 0;
  int hold_req      = 0;
  int holds_served  = 0;
  int hold_ctr      = 0;
  int cycle_cnt     = 0;
  int fail_cnt      = 0;
  int req_cnt       = 0;
  int dropped_cnt   = 0;
  int batch_cnt     = 0;
  int visit_cnt     = 0;
  int cfg_cnt       = 0;
  logic [7:0] last_cyl = 8'd0;

  cscan_disk_schedule_order u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no gap unless the idle draw hits, else mostly short, now and then long
  function automatic int pick_gap(input int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] clamp_cyl(input logic [7:0] v);
    return (v > 8'd199) ? 8'd199 : v;
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // Store one request; on the closing one, build the circular-scan order.
  task automatic schedule_request(input disk_req_t r);
    logic [7:0] sorted[$];
    logic [7:0] route[$];
    logic [7:0] head;
    logic [7:0] prev;
    int         moved;
    visit_t     v;
    if (batch_cyls.size() < MAX_REQ) batch_cyls.push_back(clamp_cyl(r.cyl));
    else dropped_cnt++;
    if (!r.closes) return;
    head   = clamp_cyl(head_reg);
    sorted = batch_cyls;
    sorted.push_back(head);
    sorted.push_back(8'd0);
    sorted.push_back(8'd199);
    sorted.sort();
    if (sweep_reg) begin
      foreach (sorted[i]) if (sorted[i] >= head) route.push_back(sorted[i]);
      foreach (sorted[i]) if (sorted[i] < head) route.push_back(sorted[i]);
    end else begin
      for (int i = sorted.size() - 1; i >= 0; i--)
        if (sorted[i] <= head) route.push_back(sorted[i]);
      for (int i = sorted.size() - 1; i >= 0; i--)
        if (sorted[i] > head) route.push_back(sorted[i]);
    end
    moved = 0;
    prev  = route[0];
    foreach (route[i]) begin
      moved += (route[i] > prev) ? route[i] - prev : prev - route[i];
      if (moved > 1023) moved = 1023;
      prev    = route[i];
      v.cyl   = route[i];
      v.last  = (i == route.size() - 1);
      v.moved = v.last ? moved[9:0] : 10'd0;
      expected_visits.push_back(v);
    end
    batch_cyls.delete();
    batch_cnt++;
  endtask

  // request sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (pending_reqs.size() != 0) begin : src_pick
        int draw;
        draw = pick_gap(src_idle_pct);
        if (draw > 0) begin
          s_tvalid <= 1'b0;
          src_gap  <= draw - 1;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_reqs[0].cyl;
          s_tlast  <= pending_reqs[0].closes;
          void'(pending_reqs.pop_front());
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver; a requested long hold takes priority over random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      sink_gap     <= 0;
      hold_ctr     <= 0;
      holds_served <= 0;
    end else if (holds_served < hold_req) begin
      m_tready <= 1'b0;
      if (hold_ctr == LONG_HOLD - 1) begin
        hold_ctr     <= 0;
        holds_served <= holds_served + 1;
      end else begin
        hold_ctr <= hold_ctr + 1;
      end
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin : sink_pick
      int draw;
      draw = pick_gap(sink_idle_pct);
      m_tready <= (draw == 0);
      sink_gap <= (draw > 0) ? draw - 1 : 0;
    end
  end

  // monitor: register writes, accepted requests, emitted visits
  always @(posedge clk) begin : watch
    visit_t got;
    visit_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_cnt++;
        case (cfg_index)
          CFG_HEAD_POSITION: head_reg  = cfg_data;
          CFG_SWEEP_UP:      sweep_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        req_cnt++;
        schedule_request('{cyl: s_tdata, closes: s_tlast});
      end
      if (m_tvalid && m_tready) begin
        visit_cnt++;
        got.cyl   = m_tdata[7:0];
        got.moved = m_tdata[17:8];
        got.last  = m_tlast;
        if (expected_visits.size() == 0) begin
          note_failure($sformatf("unexpected visit cyl=%0d last=%0b moved=%0d",
                                 got.cyl, got.last, got.moved));
        end else begin
          want = expected_visits.pop_front();
          if (got.cyl !== want.cyl || got.last !== want.last || got.moved !== want.moved)
            note_failure($sformatf("visit %0d: exp cyl=%0d last=%0b moved=%0d, got cyl=%0d last=%0b moved=%0d",
                                   visit_cnt, want.cyl, want.last, want.moved,
                                   got.cyl, got.last, got.moved));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d visits outstanding",
               cycle_cnt, expected_visits.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_req(input logic [7:0] cyl, input logic closes);
    pending_reqs.push_back('{cyl: cyl, closes: closes});
    last_cyl = cyl;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // polled off the falling edge so the clocked processes have settled
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_visits.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_cyl(input logic [7:0] head);
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd199;
      2:       return 8'($urandom_range(200, 255));
      3:       return head;
      4:       return last_cyl;
      default: return 8'($urandom_range(0, 199));
    endcase
  endfunction

  task automatic queue_batch(input logic [7:0] head, output int len);
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(17, 20);   // overfills the store
      1, 2:    len = $urandom_range(9, 16);
      default: len = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < len; i++) queue_req(rand_cyl(head), i == len - 1);
  endtask

  initial begin : stimulus
    logic [7:0] head;
    logic       up;
    int         phase_items;
    int         len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: head at 0, sweeping up; out-of-range value and repeats
    queue_req(8'd255, 1'b1);
    queue_req(8'd0, 1'b0);
    queue_req(8'd100, 1'b0);
    queue_req(8'd100, 1'b1);
    wait_until_idle();

    // head beyond the last cylinder, downward sweep; upper data bits set
    write_reg(CFG_HEAD_POSITION, 8'd255);
    write_reg(CFG_SWEEP_UP, 8'hFE);
    queue_req(8'd199, 1'b0);
    queue_req(8'd50, 1'b0);
    queue_req(8'd0, 1'b1);
    wait_until_idle();

    write_reg(CFG_HEAD_POSITION, 8'd0);
    write_reg(CFG_SWEEP_UP, 8'h00);
    queue_req(8'd7, 1'b1);
    wait_until_idle();

    // writes to unused indexes, which must leave the registers alone; both are rewritten right after
    write_reg(CFG_SPARE_IDX, 8'hAA);
    write_reg(CFG_TOP_IDX, 8'h55);
    write_reg(CFG_HEAD_POSITION, 8'd100);
    write_reg(CFG_SWEEP_UP, 8'h01);
    // full store: the closing request is dropped but still ends the batch
    for (int i = 0; i < 17; i++)
      queue_req((i == 16) ? 8'd150 : 8'((i * 37 + 5) % 200), i == 16);
    wait_until_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       head = 8'd199;
        1:       head = 8'd255;
        2:       head = 8'd0;
        default: head = 8'($urandom_range(0, 255));
      endcase
      up = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
      write_reg(CFG_HEAD_POSITION, head);
      write_reg(CFG_SWEEP_UP, 8'($urandom_range(0, 255)) & 8'hFE | {7'd0, up});
      case (p)
        0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        1:       begin src_idle_pct = 30; sink_idle_pct = 30; end
        2:       begin src_idle_pct = 0;  sink_idle_pct = 10; hold_req++; end
        3:       begin src_idle_pct = 60; sink_idle_pct = 10; end
        4:       begin src_idle_pct = 10; sink_idle_pct = 60; end
        default: begin
          src_idle_pct  = $urandom_range(0, 70);
          sink_idle_pct = $urandom_range(0, 70);
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        queue_batch(head, len);
        phase_items += len;
      end
      wait_until_idle();
    end

    if (expected_visits.size() != 0)
      note_failure($sformatf("%0d visits never emitted", expected_visits.size()));
    $display("Ran %0d requests in %0d batches (%0d dropped on a full store), %0d visits",
             req_cnt, batch_cnt, dropped_cnt, visit_cnt);
    $display("with %0d register writes, both sweep directions and a long output hold",
             cfg_cnt);
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
